// File: rtl/mau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Operation codes, controller command and status types.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam logic [2:0] OP_REDUCE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_POW    = 3'd5;
    localparam logic [2:0] OP_INV    = 3'd6;
    localparam logic [2:0] OP_NEG    = 3'd7;

    localparam logic [29:0] MOD_RESET = 30'd1000000007;

    // Remainder unit source selection.
    localparam logic [2:0] RSRC_A     = 3'd0;
    localparam logic [2:0] RSRC_B     = 3'd1;
    localparam logic [2:0] RSRC_WIDE  = 3'd2;
    localparam logic [2:0] RSRC_MACC  = 3'd3;
    localparam logic [2:0] RSRC_MSQ   = 3'd4;
    localparam logic [2:0] RSRC_MAB   = 3'd5;
    localparam logic [2:0] RSRC_MAACC = 3'd6;

    // Destination of a finished remainder.
    localparam logic [2:0] RDST_A    = 3'd0;
    localparam logic [2:0] RDST_B    = 3'd1;
    localparam logic [2:0] RDST_ACC  = 3'd2;
    localparam logic [2:0] RDST_SQ   = 3'd3;
    localparam logic [2:0] RDST_RES  = 3'd4;

    typedef struct packed {
        logic       load;       // capture request and set up operands
        logic       rem_start;  // start a remainder
        logic [2:0] rem_src;
        logic [2:0] rem_dst;
        logic       exp_shift;  // drop exponent LSB
        logic       fin;        // final step marker, not used by the datapath
        logic       out_load;   // place result in the output register
    } mau_cmd_t;

    typedef struct packed {
        logic       rem_done;
        logic       exp_zero;
        logic       exp_lsb;
        logic       a_zero;
        logic       b_zero;
        logic [2:0] op;
    } mau_sts_t;

endpackage

// File: rtl/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Residue arithmetic over a configured modulus, powers by square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: a request word (req_type, operand_a, operand_b, wide_operand) is
// taken when in_valid is high and in_stall is low. One result word (result,
// zero_divide) is offered with out_valid and taken when out_stall is low.
// The unit handles one word at a time; in_stall is high from acceptance until
// the result is placed in the output register, which then frees the input
// side even while the receiver still stalls the result.
// Every operand and product reduction runs through one bit-serial remainder
// unit that takes a 64-bit dividend one bit at a time. A power squares once
// for each bit of the exponent and multiplies once for each one in it;
// inverse uses the exponent modulus minus two, and divide adds one more
// product. A stalled result holds in the output register and delays the
// next result. Reset loads the modulus 1000000007 and empties the unit. The
// modulus is written through cfg_we and cfg_data; the user must write it only
// while the unit is idle, since the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int EXP_WIDTH = 64,
    parameter int RES_WIDTH = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [29:0] operand_a,
    input  logic [29:0] operand_b,
    input  logic [63:0] wide_operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] result,
    output logic        zero_divide
);

    mau_cmd_t cmd;
    mau_sts_t sts;

    // The controller owns the handshake; the datapath owns all arithmetic.
    mau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mau_datapath #(
        .EXP_WIDTH (EXP_WIDTH),
        .RES_WIDTH (RES_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .wide_operand (wide_operand),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .zero_divide  (zero_divide)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(result))
        else $error("stalled result changed");
    a_zd_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_divide) |-> result == '0)
        else $error("zero divide with nonzero result");
`endif

endmodule

// File: rtl/mau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic datapath
// Operand registers, one multiplier and a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module mau_datapath
    import mau_pkg::*;
#(
    parameter int EXP_WIDTH = 64,
    parameter int RES_WIDTH = 30
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [29:0]          cfg_data,
    input  logic [2:0]           req_type,
    input  logic [29:0]          operand_a,
    input  logic [29:0]          operand_b,
    input  logic [63:0]          wide_operand,
    input  mau_cmd_t             cmd,
    output mau_sts_t             sts,
    output logic [29:0]          result,
    output logic                 zero_divide
);

    localparam int WW = 64;
    localparam int CW = $clog2(WW + 1);

    logic [RES_WIDTH-1:0] mod_reg;
    logic [RES_WIDTH-1:0] m;
    logic [2:0]           op_reg;
    logic [RES_WIDTH-1:0] a_reg, b_reg, acc_reg, sq_reg, res_reg;
    logic [63:0]          w_reg, w_next;
    logic [63:0]          e_reg;
    logic                 wneg_reg;

    // Remainder unit state.
    logic [63:0]          rsh_reg;
    logic [RES_WIDTH:0]   rr_reg;
    logic [CW-1:0]        rcnt_reg;
    logic                 rbusy_reg;
    logic                 rdone_reg;
    logic [2:0]           rdst_reg;
    logic [RES_WIDTH+1:0] rtrial;
    logic [RES_WIDTH:0]   rshift;
    logic [RES_WIDTH-1:0] rval;
    logic [63:0]          rsrc;

    logic [29:0]          res_out_reg;
    logic                 zd_reg;
    logic [RES_WIDTH-1:0] fin_val;
    logic                 fin_zd;
    logic [RES_WIDTH:0]   sum;

    assign m = (mod_reg < RES_WIDTH'(2)) ? RES_WIDTH'(2) : mod_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            mod_reg <= MOD_RESET[RES_WIDTH-1:0];
        else if (cfg_we)
            mod_reg <= cfg_data[RES_WIDTH-1:0];
    end

    // Select remainder source; products use the shared multiplier.
    logic [RES_WIDTH-1:0] mx, my;
    always_comb begin
        mx = acc_reg;
        my = sq_reg;
        unique case (cmd.rem_src)
            RSRC_MSQ:   begin mx = sq_reg; my = sq_reg;  end
            RSRC_MAB:   begin mx = a_reg;  my = b_reg;   end
            RSRC_MAACC: begin mx = a_reg;  my = acc_reg; end
            default:    begin mx = acc_reg; my = sq_reg; end
        endcase
    end

    logic [2*RES_WIDTH-1:0] mprod;
    assign mprod = {{RES_WIDTH{1'b0}}, mx} * {{RES_WIDTH{1'b0}}, my};

    always_comb begin
        unique case (cmd.rem_src)
            RSRC_A:    rsrc = 64'(a_reg);
            RSRC_B:    rsrc = 64'(b_reg);
            RSRC_WIDE: rsrc = w_reg;
            default:   rsrc = 64'(mprod);
        endcase
    end

    assign rshift = {rr_reg[RES_WIDTH-1:0], rsh_reg[63]};
    assign rtrial = {1'b0, rshift} - {2'b00, m};
    assign rval   = rr_reg[RES_WIDTH-1:0];
    assign w_next = wide_operand[63] ? (64'd0 - wide_operand) : wide_operand;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rbusy_reg <= 1'b0;
            rdone_reg <= 1'b0;
        end else begin
            rdone_reg <= 1'b0;
            if (cmd.rem_start) begin
                rbusy_reg <= 1'b1;
            end else if (rbusy_reg && rcnt_reg == CW'(1)) begin
                rbusy_reg <= 1'b0;
                rdone_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.rem_start) begin
            rsh_reg  <= rsrc;
            rr_reg   <= '0;
            rcnt_reg <= CW'(WW);
            rdst_reg <= cmd.rem_dst;
        end else if (rbusy_reg) begin
            rsh_reg  <= {rsh_reg[62:0], 1'b0};
            rcnt_reg <= rcnt_reg - CW'(1);
            rr_reg   <= rtrial[RES_WIDTH+1] ? rshift : rtrial[RES_WIDTH:0];
        end
    end

    // For a power the sign is the top bit of the exponent field; for a
    // reduction it is the top bit of the full wide operand.
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            op_reg   <= req_type;
            a_reg    <= operand_a[RES_WIDTH-1:0];
            b_reg    <= operand_b[RES_WIDTH-1:0];
            w_reg    <= (req_type == OP_REDUCE) ? w_next : wide_operand;
            if (req_type == OP_POW) begin
                wneg_reg <= wide_operand[EXP_WIDTH-1];
                e_reg    <= 64'(wide_operand[EXP_WIDTH-1:0]);
            end else begin
                wneg_reg <= wide_operand[63];
                e_reg    <= 64'(m) - 64'd2;
            end
            acc_reg  <= RES_WIDTH'(1);
        end else begin
            if (cmd.exp_shift)
                e_reg <= e_reg >> 1;
            if (rdone_reg) begin
                unique case (rdst_reg)
                    RDST_A:   a_reg   <= rval;
                    RDST_B:   b_reg   <= rval;
                    RDST_ACC: acc_reg <= rval;
                    RDST_SQ:  sq_reg  <= rval;
                    default:  res_reg <= rval;
                endcase
            end
        end
    end

    // Final combination of register contents.
    always_comb begin
        sum     = {1'b0, a_reg} + {1'b0, b_reg};
        fin_val = res_reg;
        fin_zd  = 1'b0;
        unique case (op_reg)
            OP_REDUCE: fin_val = (wneg_reg && res_reg != '0) ? m - res_reg : res_reg;
            OP_ADD:    fin_val = (sum >= {1'b0, m}) ? RES_WIDTH'(sum - {1'b0, m})
                                                    : sum[RES_WIDTH-1:0];
            OP_SUB:    fin_val = (a_reg >= b_reg) ? a_reg - b_reg : a_reg + (m - b_reg);
            OP_NEG:    fin_val = (a_reg == '0) ? '0 : m - a_reg;
            OP_POW:    fin_val = acc_reg;
            OP_INV:    begin fin_val = a_reg == '0 ? '0 : acc_reg; fin_zd = a_reg == '0; end
            OP_DIV:    begin fin_val = b_reg == '0 ? '0 : res_reg; fin_zd = b_reg == '0; end
            default:   fin_val = res_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            res_out_reg <= 30'(fin_val);
            zd_reg      <= fin_zd;
        end
    end

    assign result      = res_out_reg;
    assign zero_divide = zd_reg;

    assign sts.rem_done = rdone_reg;
    assign sts.exp_zero = (e_reg == '0) || (op_reg == OP_POW && wneg_reg);
    assign sts.exp_lsb  = e_reg[0];
    assign sts.a_zero   = (a_reg == '0);
    assign sts.b_zero   = (b_reg == '0);
    assign sts.op       = op_reg;

    logic unused;
    assign unused = cmd.fin;

`ifndef SYNTH
    a_rem_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem_start |=> rbusy_reg)
        else $error("remainder did not start");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rdone_reg |-> (rr_reg < {1'b0, m}))
        else $error("remainder out of range");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        rbusy_reg && rcnt_reg != CW'(1) |-> !cmd.rem_start)
        else $error("remainder restarted while busy");
`endif

endmodule

// File: rtl/mau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic controller
// Sequences operand reduction, square-and-multiply and result delivery.
// ----------------------------------------------------------------------------
module mau_ctrl
    import mau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  mau_sts_t sts,
    output mau_cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_REDA   = 4'd1;
    localparam logic [3:0] S_REDB   = 4'd2;
    localparam logic [3:0] S_SQ0    = 4'd3;
    localparam logic [3:0] S_LOOP   = 4'd4;
    localparam logic [3:0] S_MULW   = 4'd5;
    localparam logic [3:0] S_SQW    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DIVM   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       busy_reg, busy_next;
    logic       ov_reg, ov_next;
    logic       started_reg, started_next;

    assign in_stall  = busy_reg;
    assign out_valid = ov_reg;

    always_comb begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        ov_next      = ov_reg;
        started_next = 1'b0;
        cmd          = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_REDA;
                    started_next = 1'b1;
                end
            end
            S_REDA: begin
                if (started_reg) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = (sts.op == OP_REDUCE) ? RSRC_WIDE : RSRC_A;
                    cmd.rem_dst   = (sts.op == OP_REDUCE) ? RDST_RES : RDST_A;
                end else if (sts.rem_done) begin
                    state_next = (sts.op == OP_REDUCE) ? S_FIN : S_REDB;
                    started_next = 1'b1;
                end
            end
            S_REDB: begin
                if (started_reg) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = RSRC_B;
                    cmd.rem_dst   = RDST_B;
                end else if (sts.rem_done) begin
                    started_next = 1'b1;
                    priority if (sts.op == OP_POW || sts.op == OP_INV || sts.op == OP_DIV)
                        state_next = S_SQ0;
                    else if (sts.op == OP_MUL)
                        state_next = S_DIVM;
                    else
                        state_next = S_FIN;
                end
            end
            S_SQ0: begin
                // Seed the square register with the base through a trivial remainder.
                if (started_reg) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = (sts.op == OP_DIV) ? RSRC_B : RSRC_A;
                    cmd.rem_dst   = RDST_SQ;
                end else if (sts.rem_done) begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (sts.exp_zero) begin
                    state_next   = (sts.op == OP_DIV) ? S_DIVM : S_FIN;
                    started_next = 1'b1;
                end else if (sts.exp_lsb) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = RSRC_MACC;
                    cmd.rem_dst   = RDST_ACC;
                    state_next    = S_MULW;
                end else begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = RSRC_MSQ;
                    cmd.rem_dst   = RDST_SQ;
                    state_next    = S_SQW;
                end
            end
            S_MULW: begin
                if (sts.rem_done) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = RSRC_MSQ;
                    cmd.rem_dst   = RDST_SQ;
                    state_next    = S_SQW;
                end
            end
            S_SQW: begin
                if (sts.rem_done) begin
                    cmd.exp_shift = 1'b1;
                    state_next    = S_LOOP;
                end
            end
            S_DIVM: begin
                // Multiply reduces a*b; divide reduces a times the inverse in acc.
                if (started_reg) begin
                    cmd.rem_start = 1'b1;
                    cmd.rem_src   = (sts.op == OP_DIV) ? RSRC_MAACC : RSRC_MAB;
                    cmd.rem_dst   = RDST_RES;
                end else if (sts.rem_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!ov_reg || !out_stall) begin
                    cmd.fin      = 1'b1;
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    busy_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            ov_reg      <= ov_next;
            started_reg <= started_next;
        end
    end

`ifndef SYNTH
    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !busy_reg)
        else $error("busy while idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE && !busy_reg)
        else $error("load outside idle");
    a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> ov_reg)
        else $error("result not presented");
`endif

endmodule

// File: test/modular_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Checks every word against an expected result, typed in or from a
// predictor. First a short table of directed words, then random words
// under several moduli, including the smallest and largest values of the
// modulus register. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
    import mau_pkg::*;

    // The limit must cover the slowest word (the largest positive 64-bit
    // exponent) plus a long receiver stall or a long sender gap, and it
    // leaves a wide margin.
    localparam int IDLE_LIMIT    = 60000;
    localparam int LONG_HOLD     = 3000;
    localparam int WORDS_PER_MOD = 16;

    // One expected result word.
    typedef struct {
        logic [29:0] residue;
        logic        div_zero;
    } residue_word_t;

    // One row of the directed table. When known is set, the expected result
    // is typed into the row. Otherwise the predictor supplies it.
    typedef struct {
        logic [2:0]  op;
        logic [29:0] a;
        logic [29:0] b;
        logic [63:0] w;
        bit          known;
        logic [29:0] residue;
        logic        div_zero;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [29:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  req_type = OP_REDUCE;
    logic [29:0] operand_a = '0;
    logic [29:0] operand_b = '0;
    logic [63:0] wide_operand = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [29:0] result;
    logic        zero_divide;

    // Results still owed by the unit, oldest first.
    residue_word_t pending_results[$];
    // Copy of the modulus register, updated on every write.
    logic [29:0]   modulus_shadow = MOD_RESET;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    // calm_mode turns off all idling on both sides for a stretch.
    bit            calm_mode = 1'b0;
    // hold_request asks the receiver for one long stall.
    bit            hold_request = 1'b0;

    modular_arithmetic_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .wide_operand (wide_operand),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result),
        .zero_divide  (zero_divide)
    );

    always #6 clk = ~clk;

    // Square-and-multiply. The operands stay below 2^30, so every product
    // fits in 64 bits.
    function automatic logic [63:0] power_residue(input logic [63:0] base,
                                                  input logic [63:0] expo,
                                                  input logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1 % m;
        sq  = base % m;
        while (expo != 0)
        begin
            if (expo[0])
                acc = (acc * sq) % m;
            sq   = (sq * sq) % m;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Computes the result word that the unit owes for one request word.
    function automatic residue_word_t predict_residue(input logic [2:0]  op,
                                                      input logic [29:0] a_in,
                                                      input logic [29:0] b_in,
                                                      input logic [63:0] w,
                                                      input logic [29:0] mod_reg);
        residue_word_t out;
        logic [63:0]   m;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [63:0]   mag;
        logic [63:0]   r;
        // A modulus of 0 or 1 acts as 2.
        m   = (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
        a   = 64'(a_in) % m;
        b   = 64'(b_in) % m;
        r   = 0;
        out.div_zero = 1'b0;
        case (op)
            OP_REDUCE:
            begin
                if (!w[63])
                begin
                    r = w % m;
                end
                else
                begin
                    mag = -w;
                    r   = (m - mag % m) % m;
                end
            end
            OP_ADD: r = (a + b) % m;
            OP_SUB: r = (a + m - b) % m;
            OP_MUL: r = (a * b) % m;
            OP_DIV:
            begin
                if (b == 0)
                    out.div_zero = 1'b1;
                else
                    r = (a * power_residue(b, m - 2, m)) % m;
            end
            OP_POW: r = w[63] ? 64'd1 % m : power_residue(a, w, m);
            OP_INV:
            begin
                if (a == 0)
                    out.div_zero = 1'b1;
                else
                    r = power_residue(a, m - 2, m);
            end
            default: r = (m - a) % m;
        endcase
        out.residue = r[29:0];
        return out;
    endfunction

    // Offers one request word, waits until the unit takes it, records the
    // expected result, and then idles the input for a random gap.
    task automatic send_word(input logic [2:0]  op,
                             input logic [29:0] a,
                             input logic [29:0] b,
                             input logic [63:0] w,
                             input bit          known,
                             input logic [29:0] known_residue,
                             input logic        known_div_zero);
        residue_word_t expected;
        int            pick;
        int            gap;
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= op;
        operand_a    <= a;
        operand_b    <= b;
        wide_operand <= w;
        do
            @(posedge clk);
        while (in_stall);
        if (known)
        begin
            expected.residue  = known_residue;
            expected.div_zero = known_div_zero;
        end
        else
        begin
            expected = predict_residue(op, a, b, w, modulus_shadow);
        end
        pending_results.insert(pending_results.size(), expected);
        // Mostly no gap, sometimes a short one, and now and then a long one.
        pick = $urandom_range(0, 99);
        if (calm_mode || pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(30, 300);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Waits until every result has come back, so the unit is idle, then
    // writes the modulus register.
    task automatic write_modulus(input logic [29:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        modulus_shadow = value;
    endtask

    // Residue operand: mostly the full 30-bit range or values below the
    // modulus, with zero and modulus minus one mixed in.
    function automatic logic [29:0] random_operand();
        logic [29:0] m;
        int          pick;
        m    = (modulus_shadow < 2) ? 30'd2 : modulus_shadow;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return m - 30'd1;
        else if (pick < 6)
            return 30'($urandom);
        else
            return 30'($urandom_range(0, m - 1));
    endfunction

    // Wide operand. Powers mostly get short exponents to keep the run short;
    // a few get negative or full 64-bit ones.
    function automatic logic [63:0] random_wide(input logic [2:0] op);
        logic [63:0] w;
        int          pick;
        w = {$urandom, $urandom};
        if (op != OP_POW)
            return w;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return 64'($urandom_range(0, 40));
        else if (pick < 88)
            return w | 64'h8000_0000_0000_0000;
        else
            return w & 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    // The receiver. It stalls at random, holds off for one long stretch
    // on request, and goes quiet while calm_mode is set.
    initial
    begin
        int pick;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (calm_mode || pick < 65)
            begin
                out_stall <= 1'b0;
            end
            else if (pick < 95)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge clk);
            end
        end
    end

    // Compares each result word the receiver takes with the oldest
    // expectation.
    always @(posedge clk)
    begin
        residue_word_t expected;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected: result %0d zero_divide %0b",
                         $time, result, zero_divide);
                mismatch_count++;
            end
            else
            begin
                expected = pending_results.pop_front();
                if (result !== expected.residue)
                begin
                    $display("%0t: result expected %0d actual %0d",
                             $time, expected.residue, result);
                    mismatch_count++;
                end
                if (zero_divide !== expected.div_zero)
                begin
                    $display("%0t: zero_divide expected %0b actual %0b",
                             $time, expected.div_zero, zero_divide);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Directed words under the reset modulus 1000000007. Rows that mark
    // known carry their expected result.
    localparam logic [29:0] P  = 30'd1000000007;
    localparam logic [29:0] MX = 30'h3FFF_FFFF;
    directed_row_t directed_rows[] = '{
        '{OP_REDUCE, 30'd0, 30'd0, 64'd0,                   1'b1, 30'd0,  1'b0},
        '{OP_REDUCE, 30'd0, 30'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, P - 1,  1'b0},
        '{OP_REDUCE, 30'd0, 30'd0, 64'h8000_0000_0000_0000, 1'b0, 30'd0,  1'b0},
        '{OP_REDUCE, 30'd0, 30'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0,  1'b0},
        '{OP_ADD,    P - 1, 30'd1, 64'd0,                   1'b1, 30'd0,  1'b0},
        '{OP_ADD,    MX,    MX,    64'd0,                   1'b0, 30'd0,  1'b0},
        '{OP_SUB,    30'd0, 30'd1, 64'd0,                   1'b1, P - 1,  1'b0},
        '{OP_SUB,    MX,    30'd0, 64'd0,                   1'b0, 30'd0,  1'b0},
        '{OP_MUL,    MX,    MX,    64'd0,                   1'b0, 30'd0,  1'b0},
        '{OP_DIV,    30'd5, 30'd0, 64'd0,                   1'b1, 30'd0,  1'b1},
        '{OP_DIV,    30'd5, P,     64'd0,                   1'b1, 30'd0,  1'b1},
        '{OP_DIV,    30'd6, 30'd3, 64'd0,                   1'b1, 30'd2,  1'b0},
        '{OP_DIV,    30'd1, 30'd2, 64'd0,                   1'b0, 30'd0,  1'b0},
        '{OP_POW,    30'd0, 30'd0, 64'd0,                   1'b1, 30'd1,  1'b0},
        '{OP_POW,    30'd2, 30'd0, 64'd10,                  1'b1, 30'd1024, 1'b0},
        '{OP_POW,    30'd7, 30'd0, -64'sd5,                 1'b1, 30'd1,  1'b0},
        '{OP_POW,    30'd3, 30'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0,  1'b0},
        '{OP_POW,    MX,    30'd0, 64'h5555_AAAA_0F0F_F0F0, 1'b0, 30'd0,  1'b0},
        '{OP_INV,    30'd0, 30'd0, 64'd0,                   1'b1, 30'd0,  1'b1},
        '{OP_INV,    P,     30'd0, 64'd0,                   1'b1, 30'd0,  1'b1},
        '{OP_INV,    30'd1, 30'd0, 64'd0,                   1'b1, 30'd1,  1'b0},
        '{OP_INV,    MX,    30'd0, 64'd0,                   1'b0, 30'd0,  1'b0},
        '{OP_NEG,    30'd0, 30'd0, 64'd0,                   1'b1, 30'd0,  1'b0},
        '{OP_NEG,    30'd1, 30'd0, 64'd0,                   1'b1, P - 1,  1'b0},
        '{OP_NEG,    MX,    30'd0, 64'd0,                   1'b0, 30'd0,  1'b0}
    };

    // Moduli for the random phases: the smallest value, the two values that
    // act as 2, a small prime, the register maximum, and two large primes.
    logic [29:0] modulus_plan[] = '{30'd2, 30'd0, 30'd1, 30'd13, MX,
                                    30'd998244353, 30'd1000000007};

    initial
    begin
        logic [2:0] op;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The directed rows run without idling first, then with it.
        calm_mode = 1'b1;
        foreach (directed_rows[i])
        begin
            if (i == 12)
                calm_mode = 1'b0;
            send_word(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].w, directed_rows[i].known,
                      directed_rows[i].residue, directed_rows[i].div_zero);
        end

        // Each write waits until every result is back, which also covers
        // the sender pausing for the unit to drain.
        foreach (modulus_plan[k])
        begin
            write_modulus(modulus_plan[k]);
            calm_mode = (k == 3);
            // One long receiver hold-off while the sender keeps offering words.
            if (k == 4)
                hold_request = 1'b1;
            repeat (WORDS_PER_MOD)
            begin
                op = 3'($urandom_range(0, 7));
                send_word(op, random_operand(), random_operand(), random_wide(op),
                          1'b0, 30'd0, 1'b0);
            end
        end
        calm_mode = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/mau_pkg.sv
rtl/mau_datapath.sv
rtl/mau_ctrl.sv
rtl/modular_arithmetic_unit.sv
test/modular_arithmetic_unit_tb.sv
